// ===== src/ate_pkg.sv =====
// Package for the terminal escape engine: constants, command codes, queue entry types.
// Used by every module in src; depends on nothing.
package ate_pkg;

    localparam int MaxParams = 16;
    localparam int PidxW     = $clog2(MaxParams);
    localparam int PcntW     = $clog2(MaxParams + 2);
    localparam logic [13:0] ParamSat = 14'd9999;

    typedef enum logic [3:0] {
        CMD_WRITE  = 4'd0,
        CMD_FILL   = 4'd1,
        CMD_SCRUP  = 4'd2,
        CMD_SCRDN  = 4'd3,
        CMD_INS    = 4'd4,
        CMD_DEL    = 4'd5,
        CMD_BEEP   = 4'd6,
        CMD_CURREP = 4'd7,
        CMD_SIZREP = 4'd8,
        CMD_ATTR   = 4'd9
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_MUSIC  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        SEEN_NONE  = 2'd0,
        SEEN_CSI   = 2'd1,
        SEEN_OTHER = 2'd2
    } seen_t;

    // Work kinds handed from the classifier to the executor.
    typedef enum logic [3:0] {
        OP_PRINT = 4'd0,
        OP_BEEP  = 4'd1,
        OP_FF    = 4'd2,
        OP_TAB   = 4'd3,
        OP_CR    = 4'd4,
        OP_LF    = 4'd5,
        OP_BS    = 4'd6,
        OP_ESCD  = 4'd7,
        OP_ESCM  = 4'd8,
        OP_CSI   = 4'd9,
        OP_NONE  = 4'd10
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] byte_val;
    } work_t;

    typedef enum logic [2:0] {
        EX_IDLE = 3'd0,
        EX_SGR  = 3'd1,
        EX_OUT0 = 3'd2,
        EX_OUT1 = 3'd3
    } ex_state_t;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] char_code;
        logic [6:0] row;
        logic [7:0] col;
        logic [6:0] row_end;
        logic [7:0] col_end;
        logic [7:0] count;
        logic [7:0] attribute;
    } res_t;

    function automatic logic [2:0] colour_map(input logic [2:0] v);
        logic [2:0] r;
        begin
            r = {v[0], v[1], v[2]};
            return r;
        end
    endfunction

endpackage

// ===== src/ate_front.sv =====
// Front end: accepts bytes, runs the escape/CSI parser and collects parameters.
// Depends on ate_pkg. Pushes one work entry per byte that needs the executor.
module ate_front
    import ate_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              in_byte,
    output logic                    q_valid,
    input  logic                    q_ready,
    output work_t                   q_data,
    input  logic                    ex_busy,
    input  logic                    music_set,
    input  logic [PidxW-1:0]        prd_idx,
    output logic [13:0]             prd_data,
    output logic [PcntW-1:0]        pcount,
    output logic [13:0]             p0,
    output logic [13:0]             p1
);

    mode_t mode_reg, mode_next;
    seen_t seen_reg, seen_next;
    logic [PcntW-1:0] pc_reg, pc_next;
    logic [13:0] params_reg [MaxParams];
    logic clr;
    logic wr_en;
    logic [PidxW-1:0] wr_idx;
    logic [13:0] wr_val;
    logic [17:0] acc;
    logic letter, digit, take, push;
    work_t wk;

    // A CSI final hands params to the executor, so hold the parser while it works.
    assign in_ready = q_ready && !ex_busy && !q_valid;
    assign take     = in_valid && in_ready;
    assign letter   = (in_byte >= 8'h40 && in_byte <= 8'h5A) ||
                      (in_byte >= 8'h61 && in_byte <= 8'h7A);
    assign digit    = in_byte >= 8'h30 && in_byte <= 8'h39;
    assign wr_idx   = PidxW'(pc_reg - PcntW'(1));
    assign acc      = 18'(params_reg[wr_idx]) * 18'd10 + 18'(in_byte - 8'h30);
    assign wr_val   = (acc > 18'(ParamSat)) ? ParamSat : acc[13:0];
    assign prd_data = params_reg[prd_idx];
    assign pcount   = pc_reg;
    assign p0       = params_reg[0];
    assign p1       = params_reg[1];

    always_comb
    begin
        mode_next = mode_reg;
        seen_next = seen_reg;
        pc_next   = pc_reg;
        clr       = 1'b0;
        wr_en     = 1'b0;
        push      = 1'b0;
        wk.op       = OP_NONE;
        wk.byte_val = in_byte;
        if (music_set)
            mode_next = MODE_MUSIC;
        if (take)
        begin
            unique case (mode_reg)
                MODE_ESC:
                begin
                    if (seen_reg == SEEN_NONE && in_byte == 8'h5B)
                    begin
                        seen_next = SEEN_CSI;
                        clr       = 1'b1;
                        pc_next   = PcntW'(1);
                    end
                    else if (letter)
                    begin
                        mode_next = MODE_NORMAL;
                        seen_next = SEEN_NONE;
                        if (seen_reg == SEEN_CSI)
                        begin
                            wk.op = OP_CSI;
                            push  = 1'b1;
                        end
                        else if (seen_reg == SEEN_NONE && in_byte == 8'h44)
                        begin
                            wk.op = OP_ESCD;
                            push  = 1'b1;
                        end
                        else if (seen_reg == SEEN_NONE && in_byte == 8'h4D)
                        begin
                            wk.op = OP_ESCM;
                            push  = 1'b1;
                        end
                    end
                    else if (seen_reg == SEEN_CSI)
                    begin
                        if (digit)
                        begin
                            if (pc_reg >= PcntW'(1) && pc_reg <= PcntW'(MaxParams))
                                wr_en = 1'b1;
                        end
                        else if (in_byte == 8'h3B)
                        begin
                            if (pc_reg <= PcntW'(MaxParams))
                                pc_next = pc_reg + PcntW'(1);
                        end
                    end
                    else
                        seen_next = SEEN_OTHER;
                end
                MODE_MUSIC:
                begin
                    if (in_byte == 8'd14)
                        mode_next = MODE_NORMAL;
                end
                default:
                begin
                    push = 1'b1;
                    case (in_byte)
                        8'd0:  push  = 1'b0;
                        8'd7:  wk.op = OP_BEEP;
                        8'd12: wk.op = OP_FF;
                        8'd27:
                        begin
                            push      = 1'b0;
                            mode_next = MODE_ESC;
                            seen_next = SEEN_NONE;
                        end
                        8'd9:  wk.op = OP_TAB;
                        8'd13: wk.op = OP_CR;
                        8'd10: wk.op = OP_LF;
                        8'd8:  wk.op = OP_BS;
                        default: wk.op = OP_PRINT;
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            seen_reg <= SEEN_NONE;
            pc_reg   <= '0;
            q_valid  <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            seen_reg <= seen_next;
            pc_reg   <= pc_next;
            if (push)
                q_valid <= 1'b1;
            else if (q_ready)
                q_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_data <= wk;
    end

    // Params reset to zero and are cleared on CSI start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MaxParams; i++)
                params_reg[i] <= '0;
        end
        else if (clr)
        begin
            for (int i = 0; i < MaxParams; i++)
                params_reg[i] <= '0;
        end
        else if (wr_en)
            params_reg[wr_idx] <= wr_val;
    end

endmodule

// ===== src/ate_back.sv =====
// Back end: executes work entries against the cursor/attribute state, emits results.
// Depends on ate_pkg. SGR walks stored parameters one per cycle.
module ate_back
    import ate_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  work_t                   q_data,
    output logic                    busy,
    output logic                    music_set,
    output logic [PidxW-1:0]        prd_idx,
    input  logic [13:0]             prd_data,
    input  logic [PcntW-1:0]        pcount,
    input  logic [13:0]             p0,
    input  logic [13:0]             p1,
    input  logic [6:0]              rows_cfg,
    input  logic [7:0]              cols_cfg,
    input  logic                    cfg_wr,
    output logic                    out_valid,
    input  logic                    out_ready,
    output res_t                    out_data,
    output logic                    out_last
);

    ex_state_t st_reg, st_next;
    logic [6:0] crow_reg, crow_next, srow_reg, srow_next;
    logic [7:0] ccol_reg, ccol_next, scol_reg, scol_next;
    logic [7:0] attr_reg, attr_next;
    res_t r0_reg, r0_next, r1_reg, r1_next;
    logic [1:0] nres_reg, nres_next;
    logic [PidxW:0] k_reg, k_next, kmax_reg, kmax_next;
    logic [6:0] R;
    logic [7:0] C, left, bt;
    logic [8:0] tabv;
    logic [13:0] n;
    logic [14:0] sr, sc;
    logic [7:0] a;
    res_t z;

    assign R = (rows_cfg == 7'd0) ? 7'd1 : rows_cfg;
    assign C = (cols_cfg == 8'd0) ? 8'd1 : cols_cfg;
    assign n = (p0 == 14'd0) ? 14'd1 : p0;
    assign left = (C >= ccol_reg) ? C - ccol_reg + 8'd1 : 8'd1;
    assign sr = 15'(crow_reg) + 15'(n);
    assign sc = 15'(ccol_reg) + 15'(n);
    // Next tab stop: round the column down to a stop, then go one stop further.
    assign tabv = {1'b0, (ccol_reg - 8'd1) & 8'hF8} + 9'd9;
    assign bt = (((ccol_reg - 8'd2) >> 3) << 3) + 8'd1;
    assign busy = st_reg != EX_IDLE;
    assign q_ready = st_reg == EX_IDLE;
    assign prd_idx = k_reg[PidxW-1:0];
    assign out_valid = st_reg == EX_OUT0 || st_reg == EX_OUT1;
    assign out_data = (st_reg == EX_OUT1) ? r1_reg : r0_reg;
    assign out_last = (st_reg == EX_OUT1) || nres_reg == 2'd1;

    always_comb
    begin
        logic [7:0] tt;
        logic [6:0] lr;
        st_next = st_reg;
        crow_next = crow_reg;
        ccol_next = ccol_reg;
        srow_next = srow_reg;
        scol_next = scol_reg;
        attr_next = attr_reg;
        r0_next = r0_reg;
        r1_next = r1_reg;
        nres_next = nres_reg;
        k_next = k_reg;
        kmax_next = kmax_reg;
        music_set = 1'b0;
        z = '0;
        z.attribute = attr_reg;
        a = attr_reg;
        tt = 8'd0;
        lr = 7'd0;
        unique case (st_reg)
            EX_IDLE:
            begin
                if (cfg_wr)
                begin
                    if (crow_reg > R) crow_next = R;
                    if (crow_reg == 7'd0) crow_next = 7'd1;
                    if (ccol_reg > C) ccol_next = C;
                    if (ccol_reg == 8'd0) ccol_next = 8'd1;
                end
                if (q_valid)
                begin
                    nres_next = 2'd0;
                    r0_next = z;
                    r1_next = z;
                    case (q_data.op)
                        OP_PRINT:
                        begin
                            r0_next.command = CMD_WRITE;
                            r0_next.char_code = q_data.byte_val;
                            r0_next.row = crow_reg;
                            r0_next.col = ccol_reg;
                            nres_next = 2'd1;
                            if (ccol_reg >= C)
                            begin
                                ccol_next = 8'd1;
                                if (crow_reg >= R)
                                begin
                                    crow_next = R;
                                    r1_next.command = CMD_SCRUP;
                                    r1_next.count = 8'd1;
                                    nres_next = 2'd2;
                                end
                                else
                                    crow_next = crow_reg + 7'd1;
                            end
                            else
                                ccol_next = ccol_reg + 8'd1;
                        end
                        OP_BEEP:
                        begin
                            r0_next.command = CMD_BEEP;
                            nres_next = 2'd1;
                        end
                        OP_FF:
                        begin
                            r0_next.command = CMD_FILL;
                            r0_next.row = 7'd1; r0_next.col = 8'd1;
                            r0_next.row_end = R; r0_next.col_end = C;
                            nres_next = 2'd1;
                            crow_next = 7'd1; ccol_next = 8'd1;
                        end
                        OP_TAB:
                        begin
                            tt = (tabv > 9'(C)) ? C : tabv[7:0];
                            if (tt > ccol_reg) ccol_next = tt;
                        end
                        OP_CR: ccol_next = 8'd1;
                        OP_LF:
                        begin
                            if (crow_reg >= R)
                            begin
                                crow_next = R;
                                r0_next.command = CMD_SCRUP;
                                r0_next.count = 8'd1;
                                nres_next = 2'd1;
                            end
                            else
                                crow_next = crow_reg + 7'd1;
                        end
                        OP_BS: if (ccol_reg > 8'd1) ccol_next = ccol_reg - 8'd1;
                        OP_ESCD:
                        begin
                            r0_next.command = CMD_SCRUP; r0_next.count = 8'd1;
                            nres_next = 2'd1;
                        end
                        OP_ESCM:
                        begin
                            r0_next.command = CMD_SCRDN; r0_next.count = 8'd1;
                            nres_next = 2'd1;
                        end
                        OP_CSI:
                        begin
                            case (q_data.byte_val)
                                8'h41: crow_next = (14'(crow_reg) > n) ?
                                                   crow_reg - n[6:0] : 7'd1;
                                8'h42: crow_next = (sr > 15'(R)) ? R : sr[6:0];
                                8'h43: ccol_next = (sc > 15'(C)) ? C : sc[7:0];
                                8'h44: ccol_next = (14'(ccol_reg) > n) ?
                                                   ccol_reg - n[7:0] : 8'd1;
                                8'h45:
                                begin
                                    crow_next = (sr > 15'(R)) ? R : sr[6:0];
                                    ccol_next = 8'd1;
                                end
                                8'h48, 8'h66:
                                begin
                                    crow_next = (p0 == 14'd0) ? 7'd1 :
                                                (p0 > 14'(R)) ? R : p0[6:0];
                                    if (pcount < PcntW'(2) || p1 == 14'd0)
                                        ccol_next = 8'd1;
                                    else
                                        ccol_next = (p1 > 14'(C)) ? C : p1[7:0];
                                end
                                8'h4A, 8'h4B:
                                begin
                                    r0_next.command = CMD_FILL;
                                    r1_next.command = CMD_FILL;
                                    r0_next.row = crow_reg;
                                    r0_next.row_end = crow_reg;
                                    if (p0 == 14'd0)
                                    begin
                                        r0_next.col = ccol_reg; r0_next.col_end = C;
                                        nres_next = 2'd1;
                                        if (q_data.byte_val == 8'h4A && crow_reg < R)
                                        begin
                                            r1_next.row = crow_reg + 7'd1;
                                            r1_next.col = 8'd1;
                                            r1_next.row_end = R; r1_next.col_end = C;
                                            nres_next = 2'd2;
                                        end
                                    end
                                    else if (p0 == 14'd1)
                                    begin
                                        r0_next.col = 8'd1; r0_next.col_end = ccol_reg;
                                        nres_next = 2'd1;
                                        if (q_data.byte_val == 8'h4A && crow_reg > 7'd1)
                                        begin
                                            lr = crow_reg - 7'd1;
                                            r1_next.row = 7'd1; r1_next.col = 8'd1;
                                            r1_next.row_end = lr; r1_next.col_end = C;
                                            nres_next = 2'd2;
                                        end
                                    end
                                    else if (p0 == 14'd2)
                                    begin
                                        r0_next.col = 8'd1; r0_next.col_end = C;
                                        nres_next = 2'd1;
                                        if (q_data.byte_val == 8'h4A)
                                        begin
                                            r0_next.row = 7'd1; r0_next.row_end = R;
                                            crow_next = 7'd1; ccol_next = 8'd1;
                                        end
                                    end
                                end
                                8'h40, 8'h50:
                                begin
                                    r0_next.command = (q_data.byte_val == 8'h40) ?
                                                      CMD_INS : CMD_DEL;
                                    r0_next.row = crow_reg; r0_next.col = ccol_reg;
                                    r0_next.count = (n > 14'(left)) ? left : n[7:0];
                                    nres_next = 2'd1;
                                end
                                8'h53, 8'h54:
                                begin
                                    r0_next.command = (q_data.byte_val == 8'h53) ?
                                                      CMD_SCRUP : CMD_SCRDN;
                                    r0_next.count = (n > 14'(R)) ? 8'(R) : n[7:0];
                                    nres_next = 2'd1;
                                end
                                8'h55:
                                begin
                                    r0_next.command = CMD_FILL;
                                    r0_next.row = 7'd1; r0_next.col = 8'd1;
                                    r0_next.row_end = R; r0_next.col_end = C;
                                    r0_next.attribute = 8'd7;
                                    nres_next = 2'd1;
                                    crow_next = 7'd1; ccol_next = 8'd1;
                                end
                                8'h5A: if (ccol_reg > 8'd1) ccol_next = bt;
                                8'h4D, 8'h4E: music_set = 1'b1;
                                8'h6D:
                                begin
                                    k_next = '0;
                                    if (pcount == '0)
                                        kmax_next = (PidxW+1)'(1);
                                    else if (pcount > PcntW'(MaxParams))
                                        kmax_next = (PidxW+1)'(MaxParams);
                                    else
                                        kmax_next = (PidxW+1)'(pcount);
                                end
                                8'h6E:
                                begin
                                    if (p0 == 14'd6)
                                    begin
                                        r0_next.command = CMD_CURREP;
                                        r0_next.row = crow_reg; r0_next.col = ccol_reg;
                                        nres_next = 2'd1;
                                    end
                                    else if (p0 == 14'd255)
                                    begin
                                        r0_next.command = CMD_SIZREP;
                                        r0_next.row = R; r0_next.col = C;
                                        nres_next = 2'd1;
                                    end
                                end
                                8'h73:
                                begin
                                    srow_next = crow_reg; scol_next = ccol_reg;
                                end
                                8'h75:
                                begin
                                    if (srow_reg >= 7'd1 && srow_reg <= R &&
                                        scol_reg >= 8'd1 && scol_reg <= C)
                                    begin
                                        crow_next = srow_reg; ccol_next = scol_reg;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                    if (q_data.op == OP_CSI && q_data.byte_val == 8'h6D)
                        st_next = EX_SGR;
                    else if (nres_next != 2'd0)
                        st_next = EX_OUT0;
                end
            end
            EX_SGR:
            begin
                // One parameter per cycle.
                case (prd_data)
                    14'd0: a = 8'd7;
                    14'd1: a = attr_reg | 8'd8;
                    14'd2: a = attr_reg & 8'd247;
                    14'd5, 14'd6: a = attr_reg | 8'd128;
                    14'd7: a = (attr_reg & 8'd136) | ((attr_reg & 8'd112) >> 4) |
                               ((attr_reg & 8'd7) << 4);
                    14'd8: a = (attr_reg & 8'd112) | ((attr_reg & 8'd112) >> 4);
                    default:
                    begin
                        if (prd_data >= 14'd30 && prd_data <= 14'd37)
                            a = (attr_reg & 8'd248) |
                                8'(colour_map(3'(prd_data - 14'd30)));
                        else if (prd_data >= 14'd40 && prd_data <= 14'd47)
                            a = (attr_reg & 8'd143) |
                                {1'b0, colour_map(3'(prd_data - 14'd40)), 4'd0};
                    end
                endcase
                attr_next = a;
                k_next = k_reg + 1'b1;
                if (k_next == kmax_reg)
                begin
                    r0_next = '0;
                    r0_next.command = CMD_ATTR;
                    r0_next.attribute = a;
                    nres_next = 2'd1;
                    st_next = EX_OUT0;
                end
            end
            EX_OUT0:
                if (out_ready)
                    st_next = (nres_reg == 2'd2) ? EX_OUT1 : EX_IDLE;
            EX_OUT1:
                if (out_ready)
                    st_next = EX_IDLE;
            default: st_next = EX_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= EX_IDLE;
            crow_reg <= 7'd1;
            ccol_reg <= 8'd1;
            srow_reg <= 7'd0;
            scol_reg <= 8'd0;
            attr_reg <= 8'd7;
            nres_reg <= 2'd0;
            k_reg    <= '0;
            kmax_reg <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            crow_reg <= crow_next;
            ccol_reg <= ccol_next;
            srow_reg <= srow_next;
            scol_reg <= scol_next;
            attr_reg <= attr_next;
            nres_reg <= nres_next;
            k_reg    <= k_next;
            kmax_reg <= kmax_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg <= r0_next;
        r1_reg <= r1_next;
    end

endmodule

// ===== src/ansi_terminal_escape_engine.sv =====
// Top level of the terminal escape engine: APB registers, front parser, back executor.
// Depends on ate_pkg, ate_front, ate_back.
//
// Bytes enter on the s_axis group, one transaction per byte; display commands leave on
// m_axis, zero, one or two per byte, with tlast on the last command of a byte. The parser
// takes one byte per cycle while a byte only changes parser state (digits, ';', ESC, NUL,
// bytes swallowed in music mode or in an unknown sequence). A byte that needs the executor
// goes through a one-entry queue and holds the input until the executor is idle again,
// including while m_axis stalls. SGR ('m') walks its n stored parameters one per cycle
// (n from 1 to MaxParams) before its command is valid. Screen size registers sit at 0x0
// (rows) and 0x4 (cols); write them only while the block is idle. The cursor is clamped
// into the new size after the write, through the registered write strobe.
module ansi_terminal_escape_engine
    import ate_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // command[3:0], char_code[11:4], row[18:12], col[26:19], row_end[33:27],
    // col_end[41:34], count[49:42], attribute[57:50], zero pad [63:58]
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    logic [6:0] rows_reg;
    logic [7:0] cols_reg;
    logic wr, q_valid, q_ready, busy, music_set;
    logic cfg_wr_reg;
    work_t q_data;
    logic [PidxW-1:0] prd_idx;
    logic [13:0] prd_data;
    logic [PcntW-1:0] pcount;
    logic [13:0] p0, p1;
    res_t res;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == 1'b0) ? {25'd0, rows_reg} : {24'd0, cols_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= 7'd25;
            cols_reg <= 8'd80;
        end
        else if (wr)
        begin
            if (paddr == 3'd0) rows_reg <= pwdata[6:0];
            if (paddr == 3'd4) cols_reg <= pwdata[7:0];
        end
    end

    // Delay the write strobe so the clamp sees the new screen size.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_wr_reg <= 1'b0;
        else
            cfg_wr_reg <= wr && (paddr == 3'd0 || paddr == 3'd4);
    end

    // p0/p1 come from fixed slots of the front's register file; SGR reads the slots by index.
    ate_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_byte(s_axis_tdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .ex_busy(busy), .music_set(music_set),
        .prd_idx(prd_idx), .prd_data(prd_data), .pcount(pcount),
        .p0(p0), .p1(p1)
    );

    ate_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .busy(busy), .music_set(music_set),
        .prd_idx(prd_idx), .prd_data(prd_data), .pcount(pcount),
        .p0(p0), .p1(p1),
        .rows_cfg(rows_reg), .cols_cfg(cols_reg),
        .cfg_wr(cfg_wr_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(res), .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, res.attribute, res.count, res.col_end, res.row_end,
                           res.col, res.row, res.char_code, res.command};

endmodule
